// ===== hw/rtl/assert_macros.svh =====
// assertion macros, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define UCT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define UCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/uct_pkg.sv =====
package uct_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  localparam int POS_W  = 32;
  localparam int ANG_W  = 16;
  localparam int GAIN_W = 16;
  localparam int RATE_W = 10;
  localparam int CFG_W  = 16;
  localparam int CORD_W = 40;
  localparam int Z_W    = 33;

  localparam logic signed [Z_W-1:0] PI_Q29      = 33'sd1686629713;
  localparam logic signed [Z_W-1:0] HALF_PI_Q29 = 33'sd843314856;
  localparam logic [31:0]           TWO_PI_Q29  = 32'd3373259426;
  localparam logic [15:0]           INV_GAIN    = 16'd39797;
  localparam logic [20:0]           WRAP_RECIP  = 21'd1335088;
  localparam logic signed [39:0]    WRAP_OFS    = 40'sd138303636466;

  localparam logic signed [31:0] LIN_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] LIN_MIN = 32'sh80000000;

  localparam logic signed [31:0] ORI_GAIN   = -32'sd19661;
  localparam logic [16:0]        ORI_SMALL  = 17'd2731;
  localparam logic signed [15:0] ORI_MIN_W  = 16'sd819;

  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd4096;
  localparam logic [RATE_W-1:0] RATE_RST = 10'd10;

  typedef enum logic [1:0] {
    CFG_GAIN_X       = 2'd0,
    CFG_GAIN_Y       = 2'd1,
    CFG_GAIN_HEADING = 2'd2,
    CFG_RATE         = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                    mode;
    logic                    zero;
    logic signed [ANG_W-1:0] hd;
    logic signed [ANG_W-1:0] ang_o;
  } carry_t;

  function automatic logic signed [Z_W-1:0] atan_q29(input int unsigned i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:  a = 33'sd421657428;
      1:  a = 33'sd248918915;
      2:  a = 33'sd131521918;
      3:  a = 33'sd66762579;
      4:  a = 33'sd33510843;
      5:  a = 33'sd16771758;
      6:  a = 33'sd8387925;
      7:  a = 33'sd4194219;
      8:  a = 33'sd2097141;
      9:  a = 33'sd1048575;
      10: a = 33'sd524288;
      11: a = 33'sd262144;
      12: a = 33'sd131072;
      13: a = 33'sd65536;
      14: a = 33'sd32768;
      15: a = 33'sd16384;
      16: a = 33'sd8192;
      17: a = 33'sd4096;
      18: a = 33'sd2048;
      19: a = 33'sd1024;
      20: a = 33'sd512;
      21: a = 33'sd256;
      22: a = 33'sd128;
      23: a = 33'sd64;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/unicycle_tracking_controller.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | mode, pose, reference points, angle error
// out     | output    | out_valid / out_stall| linear_speed, angular_speed
// cfg     | input     | cfg_wr_en            | cfg_addr, cfg_wdata
// one beat accepted per cycle while in_stall is low; the pipeline has one register stage per
// cordic iteration plus the gain, scaling and angle wrap stages
// rst_n is synchronous; it clears the stage valid bits and loads the register defaults
// a stall holds only full stages; empty stages keep filling behind a stalled output
module unicycle_tracking_controller #(
  parameter int CORDIC_STEPS = uct_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_addr,
  input  logic [uct_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_mode,
  input  logic signed [uct_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [uct_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [uct_pkg::ANG_W-1:0]    in_heading,
  input  logic signed [uct_pkg::POS_W-1:0]    in_ref_x_now,
  input  logic signed [uct_pkg::POS_W-1:0]    in_ref_y_now,
  input  logic signed [uct_pkg::POS_W-1:0]    in_ref_x_next,
  input  logic signed [uct_pkg::POS_W-1:0]    in_ref_y_next,
  input  logic signed [uct_pkg::ANG_W-1:0]    in_angle_error,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [uct_pkg::POS_W-1:0]    out_linear_speed,
  output logic signed [uct_pkg::ANG_W-1:0]    out_angular_speed
);

  `include "assert_macros.svh"

  localparam int N      = CORDIC_STEPS;
  localparam int ST_PRE = 3;
  localparam int ST_COR = 4;
  localparam int ST_P1  = ST_COR + N;
  localparam int NS     = ST_P1 + 12;
  localparam int CW     = uct_pkg::CORD_W;
  localparam int ZW     = uct_pkg::Z_W;

  // configuration
  logic [uct_pkg::GAIN_W-1:0] gain_x_r, gain_y_r, gain_hd_r;
  logic [uct_pkg::RATE_W-1:0] rate_r;
  logic [uct_pkg::GAIN_W-1:0] gain_x_nxt, gain_y_nxt, gain_hd_nxt;
  logic [uct_pkg::RATE_W-1:0] rate_nxt;

  always_comb begin
    gain_x_nxt  = gain_x_r;
    gain_y_nxt  = gain_y_r;
    gain_hd_nxt = gain_hd_r;
    rate_nxt    = rate_r;
    if (cfg_wr_en) begin
      case (uct_pkg::cfg_idx_t'(cfg_addr))
        uct_pkg::CFG_GAIN_X:       gain_x_nxt  = cfg_wdata;
        uct_pkg::CFG_GAIN_Y:       gain_y_nxt  = cfg_wdata;
        uct_pkg::CFG_GAIN_HEADING: gain_hd_nxt = cfg_wdata;
        uct_pkg::CFG_RATE:         rate_nxt    = cfg_wdata[uct_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_x_r  <= uct_pkg::GAIN_RST;
      gain_y_r  <= uct_pkg::GAIN_RST;
      gain_hd_r <= uct_pkg::GAIN_RST;
      rate_r    <= uct_pkg::RATE_RST;
    end else begin
      gain_x_r  <= gain_x_nxt;
      gain_y_r  <= gain_y_nxt;
      gain_hd_r <= gain_hd_nxt;
      rate_r    <= rate_nxt;
    end
  end

  // stage valid bits and advance chain
  logic [NS:0]   adv;
  logic [NS-1:0] vld_r, vld_nxt, vld_prev;

  assign adv[NS]  = !out_stall;
  assign vld_prev = {vld_r[NS-2:0], in_valid};

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_adv
      assign adv[k]     = !vld_r[k] || adv[k+1];
      assign vld_nxt[k] = adv[k] ? vld_prev[k] : vld_r[k];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NS-1];

  // side data carried along every stage
  uct_pkg::carry_t car_r [NS];
  uct_pkg::carry_t car_nxt [NS];

  // orientation mode result
  logic signed [31:0] oprod;
  logic signed [32:0] oround;
  logic [16:0]        amag;
  logic signed [15:0] ang_o;

  assign oprod  = 32'(in_angle_error) * uct_pkg::ORI_GAIN;
  assign oround = 33'(oprod) + 33'sd32768;
  assign amag   = in_angle_error[15] ? 17'(-18'(in_angle_error)) : 17'(in_angle_error);

  always_comb begin
    if (in_angle_error == '0) begin
      ang_o = '0;
    end else if (amag < uct_pkg::ORI_SMALL) begin
      ang_o = in_angle_error[15] ? uct_pkg::ORI_MIN_W : -uct_pkg::ORI_MIN_W;
    end else begin
      ang_o = oround[31:16];
    end
  end

  logic signed [CW-1:0] dx_r, dy_r;
  logic signed [CW-1:0] cx_r [N+1];
  logic signed [CW-1:0] cy_r [N+1];
  logic signed [ZW-1:0] cz_r [N+1];

  always_comb begin
    car_nxt[0].mode  = in_mode;
    car_nxt[0].zero  = 1'b0;
    car_nxt[0].hd    = in_heading;
    car_nxt[0].ang_o = ang_o;
    for (int j = 1; j < NS; j++) begin
      car_nxt[j] = car_r[j-1];
    end
    car_nxt[ST_PRE].zero = (dx_r == '0) && (dy_r == '0);
  end

  generate
    for (k = 0; k < NS; k++) begin : g_car
      always_ff @(posedge clk) begin
        if (adv[k]) car_r[k] <= car_nxt[k];
      end
    end
  endgenerate

  // stage 0: position errors
  logic signed [32:0] ex_r, ey_r, ex_nxt, ey_nxt;
  logic signed [31:0] px_r, py_r, nx_r, ny_r;
  logic signed [31:0] px2_r, py2_r, nx2_r, ny2_r;

  assign ex_nxt = 33'(in_ref_x_now) - 33'(in_pos_x);
  assign ey_nxt = 33'(in_ref_y_now) - 33'(in_pos_y);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ex_r <= ex_nxt;
      ey_r <= ey_nxt;
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      nx_r <= in_ref_x_next;
      ny_r <= in_ref_y_next;
    end
  end

  // stage 1: gain products
  logic signed [49:0] prodx_r, prody_r, prodx_nxt, prody_nxt;

  assign prodx_nxt = $signed({1'b0, gain_x_r}) * ex_r;
  assign prody_nxt = $signed({1'b0, gain_y_r}) * ey_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      prodx_r <= prodx_nxt;
      prody_r <= prody_nxt;
      px2_r   <= px_r;
      py2_r   <= py_r;
      nx2_r   <= nx_r;
      ny2_r   <= ny_r;
    end
  end

  // stage 2: corrected steps
  logic signed [CW-1:0] dx_nxt, dy_nxt;

  assign dx_nxt = CW'(nx2_r) - CW'(prodx_r >>> 12) - CW'(px2_r);
  assign dy_nxt = CW'(ny2_r) - CW'(prody_r >>> 12) - CW'(py2_r);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

  // stage 3: quadrant fold into the right half plane
  logic signed [CW-1:0] cx0_nxt, cy0_nxt;
  logic signed [ZW-1:0] cz0_nxt;

  always_comb begin
    cx0_nxt = dx_r;
    cy0_nxt = dy_r;
    cz0_nxt = '0;
    if (dx_r < 0) begin
      if (dy_r >= 0) begin
        cx0_nxt = dy_r;
        cy0_nxt = -dx_r;
        cz0_nxt = uct_pkg::HALF_PI_Q29;
      end else begin
        cx0_nxt = -dy_r;
        cy0_nxt = dx_r;
        cz0_nxt = -uct_pkg::HALF_PI_Q29;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_PRE]) begin
      cx_r[0] <= cx0_nxt;
      cy_r[0] <= cy0_nxt;
      cz_r[0] <= cz0_nxt;
    end
  end

  // cordic vectoring, one iteration per stage
  generate
    for (k = 0; k < N; k++) begin : g_cordic
      logic signed [CW-1:0] sx, sy, cx_nxt, cy_nxt;
      logic signed [ZW-1:0] cz_nxt;

      assign sx = cx_r[k] >>> k;
      assign sy = cy_r[k] >>> k;

      always_comb begin
        if (cy_r[k] > 0) begin
          cx_nxt = cx_r[k] + sy;
          cy_nxt = cy_r[k] - sx;
          cz_nxt = cz_r[k] + uct_pkg::atan_q29(k);
        end else begin
          cx_nxt = cx_r[k] - sy;
          cy_nxt = cy_r[k] + sx;
          cz_nxt = cz_r[k] - uct_pkg::atan_q29(k);
        end
      end

      always_ff @(posedge clk) begin
        if (adv[ST_COR+k]) begin
          cx_r[k+1] <= cx_nxt;
          cy_r[k+1] <= cy_nxt;
          cz_r[k+1] <= cz_nxt;
        end
      end
    end
  endgenerate

  // P1: heading reference, length gain products
  logic signed [ZW-1:0] th_r, th2_r, th3_r, th_nxt;
  logic signed [36:0]   lph_r, lph_nxt;
  logic [35:0]          lpl_r, lpl_nxt;

  assign th_nxt  = car_r[ST_P1-1].zero ? '0 : cz_r[N];
  assign lph_nxt = $signed(cx_r[N][CW-1:20]) * $signed({1'b0, uct_pkg::INV_GAIN});
  assign lpl_nxt = cx_r[N][19:0] * uct_pkg::INV_GAIN;

  always_ff @(posedge clk) begin
    if (adv[ST_P1]) begin
      th_r  <= th_nxt;
      lph_r <= lph_nxt;
      lpl_r <= lpl_nxt;
    end
  end

  // P2: length, heading error
  logic signed [56:0] lsum;
  logic signed [40:0] len_r, len_nxt;
  logic signed [31:0] hdq2;
  logic signed [33:0] e_r, e_nxt;

  assign lsum    = (57'(lph_r) <<< 20) + $signed({21'b0, lpl_r});
  assign len_nxt = 41'(lsum >>> 16);
  assign hdq2    = {car_r[ST_P1].hd, 16'b0};
  assign e_nxt   = 34'(th_r) - 34'(hdq2);

  always_ff @(posedge clk) begin
    if (adv[ST_P1+1]) begin
      len_r <= len_nxt;
      e_r   <= e_nxt;
      th2_r <= th_r;
    end
  end

  // P3: length range flags, heading gain product
  logic               hi_r, lo_r, hi_nxt, lo_nxt;
  logic signed [31:0] len32_r;
  logic signed [50:0] gprod_r, gprod_nxt;

  assign hi_nxt    = len_r > 41'(uct_pkg::LIN_MAX);
  assign lo_nxt    = len_r < 41'(uct_pkg::LIN_MIN);
  assign gprod_nxt = $signed({1'b0, gain_hd_r}) * e_r;

  always_ff @(posedge clk) begin
    if (adv[ST_P1+2]) begin
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
      len32_r <= len_r[31:0];
      gprod_r <= gprod_nxt;
      th3_r   <= th2_r;
    end
  end

  // P4: raw linear speed, heading command moved to a non-negative value
  logic signed [42:0] linraw_r, linraw_nxt;
  logic               hi2_r, lo2_r;
  logic signed [31:0] hdq4;
  logic signed [39:0] dcmd;
  logic [38:0]        v_r, v_nxt;

  assign linraw_nxt = len32_r * $signed({1'b0, rate_r});
  assign hdq4       = {car_r[ST_P1+2].hd, 16'b0};
  assign dcmd       = 40'(th3_r) - 40'(gprod_r >>> 12) - 40'(hdq4);
  assign v_nxt      = 39'(dcmd + uct_pkg::WRAP_OFS);

  always_ff @(posedge clk) begin
    if (adv[ST_P1+3]) begin
      linraw_r <= linraw_nxt;
      hi2_r    <= hi_r;
      lo2_r    <= lo_r;
      v_r      <= v_nxt;
    end
  end

  // P5: saturated linear speed, first quotient estimate
  logic signed [31:0] lin_r [7];
  logic signed [31:0] lin_nxt;
  logic [39:0]        qa_prod;
  logic [7:0]         qa_r;
  logic [38:0]        v2_r;

  always_comb begin
    if (rate_r == '0) begin
      lin_nxt = '0;
    end else if (hi2_r || (linraw_r > 43'(uct_pkg::LIN_MAX))) begin
      lin_nxt = uct_pkg::LIN_MAX;
    end else if (lo2_r || (linraw_r < 43'(uct_pkg::LIN_MIN))) begin
      lin_nxt = uct_pkg::LIN_MIN;
    end else begin
      lin_nxt = linraw_r[31:0];
    end
  end

  assign qa_prod = v_r[38:20] * uct_pkg::WRAP_RECIP;

  always_ff @(posedge clk) begin
    if (adv[ST_P1+4]) begin
      lin_r[0] <= lin_nxt;
      qa_r     <= qa_prod[39:32];
      v2_r     <= v_r;
    end
  end

  generate
    for (k = 1; k < 7; k++) begin : g_lin
      always_ff @(posedge clk) begin
        if (adv[ST_P1+4+k]) lin_r[k] <= lin_r[k-1];
      end
    end
  endgenerate

  // P6: first remainder
  logic [39:0] ra_full;
  logic [32:0] ra_r;

  assign ra_full = 40'(v2_r) - 40'(qa_r) * 40'(uct_pkg::TWO_PI_Q29);

  always_ff @(posedge clk) begin
    if (adv[ST_P1+5]) ra_r <= ra_full[32:0];
  end

  // P7: first correction
  logic [31:0] r1_r, r1_nxt;

  assign r1_nxt = (ra_r >= 33'(uct_pkg::TWO_PI_Q29)) ?
                  32'(ra_r - 33'(uct_pkg::TWO_PI_Q29)) : ra_r[31:0];

  always_ff @(posedge clk) begin
    if (adv[ST_P1+6]) r1_r <= r1_nxt;
  end

  // P8: scale by rate
  logic [41:0] m2_r, m2b_r, m2_nxt;

  assign m2_nxt = r1_r * rate_r;

  always_ff @(posedge clk) begin
    if (adv[ST_P1+7]) m2_r <= m2_nxt;
  end

  // P9: second quotient estimate
  logic [42:0] qb_prod;
  logic [10:0] qb_r;

  assign qb_prod = m2_r[41:20] * uct_pkg::WRAP_RECIP;

  always_ff @(posedge clk) begin
    if (adv[ST_P1+8]) begin
      qb_r  <= qb_prod[42:32];
      m2b_r <= m2_r;
    end
  end

  // P10: second remainder
  logic [42:0] rb_full;
  logic [32:0] rb_r;

  assign rb_full = 43'(m2b_r) - 43'(qb_r) * 43'(uct_pkg::TWO_PI_Q29);

  always_ff @(posedge clk) begin
    if (adv[ST_P1+9]) rb_r <= rb_full[32:0];
  end

  // P11: second correction
  logic [31:0] r2_r, r2_nxt;

  assign r2_nxt = (rb_r >= 33'(uct_pkg::TWO_PI_Q29)) ?
                  32'(rb_r - 33'(uct_pkg::TWO_PI_Q29)) : rb_r[31:0];

  always_ff @(posedge clk) begin
    if (adv[ST_P1+10]) r2_r <= r2_nxt;
  end

  // P12: wrap into the half-open range and round, output register
  logic signed [33:0] w;
  logic signed [33:0] wr;
  logic signed [31:0] out_lin_r, out_lin_nxt;
  logic signed [15:0] out_ang_r, out_ang_nxt;

  assign w  = ($signed({2'b0, r2_r}) > 34'(uct_pkg::PI_Q29)) ?
              $signed({2'b0, r2_r}) - $signed({2'b0, uct_pkg::TWO_PI_Q29}) :
              $signed({2'b0, r2_r});
  assign wr = w + 34'sd32768;

  always_comb begin
    if (car_r[NS-2].mode) begin
      out_lin_nxt = '0;
      out_ang_nxt = car_r[NS-2].ang_o;
    end else begin
      out_lin_nxt = lin_r[6];
      out_ang_nxt = wr[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      out_lin_r <= out_lin_nxt;
      out_ang_r <= out_ang_nxt;
    end
  end

  assign out_linear_speed  = out_lin_r;
  assign out_angular_speed = out_ang_r;

  `UCT_ASSERT_IMPL(a_ori_lin_zero, out_valid && car_r[NS-1].mode, out_linear_speed == '0, "turn mode beat with nonzero linear speed")
  `UCT_ASSERT_IMPL(a_ang_range, out_valid, (out_angular_speed <= 16'sd25736) && (out_angular_speed >= -16'sd25736), "angular speed out of range")
  `UCT_ASSERT_IMPL(a_stall_full, in_stall, out_valid && out_stall, "input stalled while output not stalled")
  `UCT_ASSERT_IMPL(a_wrap_rem, vld_r[ST_P1+6], r1_r < uct_pkg::TWO_PI_Q29, "angle remainder not reduced")
  `UCT_ASSERT_NEXT(a_zero_rate, out_valid && !car_r[NS-1].mode && (rate_r == '0) && adv[NS], !out_valid || car_r[NS-1].mode || (out_linear_speed == '0) || (rate_r != '0), "zero rate gave linear speed")

endmodule
